// ----- sv/sha1bsh_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1bsh_pkg
// Shared types and constants for the byte-stream SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

  // Round constants
  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  // Initial vector, index 0 is H0
  localparam logic [4:0][31:0] IV = {
    32'hc3d2e1f0, 32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [6:0] SCHED_LEN  = 7'd16;
  localparam logic [2:0] LAST_WORD  = 3'd4;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BLK_WORDS  = 16;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PRE   = 7'b0000010,
    ST_ROUND = 7'b0000100,
    ST_ADD   = 7'b0001000,
    ST_PAD   = 7'b0010000,
    ST_LEN   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  // Round function and constant, selected by round number
  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] r;
    if (t < 7'd20) begin
      r = (b & c) | (~b & d);
    end else if (t < 7'd40) begin
      r = b ^ c ^ d;
    end else if (t < 7'd60) begin
      r = (b & c) | (b & d) | (c & d);
    end else begin
      r = b ^ c ^ d;
    end
    return r;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    logic [31:0] r;
    if (t < 7'd20) begin
      r = K0;
    end else if (t < 7'd40) begin
      r = K1;
    end else if (t < 7'd60) begin
      r = K2;
    end else begin
      r = K3;
    end
    return r;
  endfunction

endpackage

// ----- sv/sha1_byte_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher
// SHA-1 over a byte stream: packs bytes big-endian into a block RAM, runs
// one compression round per cycle and emits the five digest words on finalize.
// ----------------------------------------------------------------------------
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------------
//  in      | in_valid_i  | in_stall_o  | kind_i, data_byte_i
//  out     | out_valid_o | out_stall_i | digest_word_o, digest_last_o
//
// A data byte is taken in the idle state; the byte that fills a block starts
// a compression: one read-prime step, 80 rounds and one step to fold into the
// hash words, run by the single round unit reading the schedule out of the
// block RAM. Finalize pushes one pad byte per cycle up to offset 56, then the
// eight length bytes (one or two blocks, each compressed in turn), then offers
// five digest words. Reset clears counters and loads the initial vector; the
// block RAM is not cleared. in_stall_o is high whenever the block is busy;
// out_stall_i holds the current digest word in place.
module sha1_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic        digest_last_o
);

  sha1bsh_pkg::state_e state_q, state_d;

  logic [5:0]        fill_q, fill_d;       // byte position in the block
  logic [23:0]       pack_q, pack_d;       // bytes gathered toward the next word
  logic [63:0]       bits_q, bits_d;       // message length in bits
  logic [6:0]        rnd_q, rnd_d;         // round number
  logic              fin_q, fin_d;         // finalize in progress
  logic              lend_q, lend_d;       // length bytes already pushed
  logic [2:0]        oidx_q, oidx_d;       // digest word being offered
  logic [4:0][31:0]  h_q, h_d;             // chaining hash words
  logic [31:0]       a_q, b_q, c_q, d_q, e_q;
  logic [31:0]       a_d, b_d, c_d, d_d, e_d;
  logic [15:0][31:0] w_q, w_d;             // rolling schedule, index 15 newest

  // Push path shared by data bytes and padding
  logic       push_en;
  logic [7:0] push_byte;

  // Block RAM ports
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;

  // Round datapath
  logic [31:0] w_new;
  logic [31:0] w_cur;
  logic [31:0] tmp;
  logic [63:0] len_shift;

  sha1bsh_ram #(
    .WIDTH (sha1bsh_pkg::WORD_W),
    .DEPTH (sha1bsh_pkg::BLK_WORDS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Schedule expansion from fixed taps: t-3, t-8, t-14, t-16
  assign w_new = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
                  w_q[13][31]   ^ w_q[8][31]   ^ w_q[2][31]   ^ w_q[0][31]};
  // First sixteen rounds take the message word straight from the RAM
  assign w_cur = (rnd_q < sha1bsh_pkg::SCHED_LEN) ? ram_rdata : w_new;
  assign tmp   = {a_q[26:0], a_q[31:27]} + sha1bsh_pkg::round_f(rnd_q, b_q, c_q, d_q)
               + e_q + sha1bsh_pkg::round_k(rnd_q) + w_cur;

  // Length byte j sits at block offset 56 + j, most significant first
  assign len_shift = bits_q << {fill_q[2:0], 3'b000};

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    pack_d    = pack_q;
    bits_d    = bits_q;
    rnd_d     = rnd_q;
    fin_d     = fin_q;
    lend_d    = lend_q;
    oidx_d    = oidx_q;
    h_d       = h_q;
    a_d       = a_q;
    b_d       = b_q;
    c_d       = c_q;
    d_d       = d_q;
    e_d       = e_q;
    w_d       = w_q;
    push_en   = 1'b0;
    push_byte = 8'h00;
    ram_raddr = 4'd0;
    ram_we    = 1'b0;
    ram_waddr = fill_q[5:2];
    ram_wdata = {pack_q, push_byte};

    case (state_q)
      sha1bsh_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          push_en = 1'b1;
          if (kind_i) begin
            // Finalize: append the marker, then pad
            push_byte = sha1bsh_pkg::PAD_MARK;
            fin_d     = 1'b1;
            state_d   = sha1bsh_pkg::ST_PAD;
          end else begin
            push_byte = data_byte_i;
            bits_d    = bits_q + 64'd8;
          end
          if (fill_q == sha1bsh_pkg::LAST_BYTE) begin
            state_d = sha1bsh_pkg::ST_PRE;
          end
        end
      end
      sha1bsh_pkg::ST_PAD: begin
        if (fill_q == sha1bsh_pkg::LEN_OFFSET) begin
          state_d = sha1bsh_pkg::ST_LEN;
        end else begin
          push_en = 1'b1;
          if (fill_q == sha1bsh_pkg::LAST_BYTE) begin
            state_d = sha1bsh_pkg::ST_PRE;
          end
        end
      end
      sha1bsh_pkg::ST_LEN: begin
        push_en   = 1'b1;
        push_byte = len_shift[63:56];
        if (fill_q == sha1bsh_pkg::LAST_BYTE) begin
          lend_d  = 1'b1;
          state_d = sha1bsh_pkg::ST_PRE;
        end
      end
      sha1bsh_pkg::ST_PRE: begin
        // Prime the RAM read of word 0 and load the working variables
        ram_raddr = 4'd0;
        a_d       = h_q[0];
        b_d       = h_q[1];
        c_d       = h_q[2];
        d_d       = h_q[3];
        e_d       = h_q[4];
        rnd_d     = 7'd0;
        state_d   = sha1bsh_pkg::ST_ROUND;
      end
      sha1bsh_pkg::ST_ROUND: begin
        ram_raddr = rnd_q[3:0] + 4'd1;
        w_d       = {w_cur, w_q[15:1]};
        a_d       = tmp;
        b_d       = a_q;
        c_d       = {b_q[1:0], b_q[31:2]};
        d_d       = c_q;
        e_d       = d_q;
        rnd_d     = rnd_q + 7'd1;
        if (rnd_q == sha1bsh_pkg::LAST_ROUND) begin
          state_d = sha1bsh_pkg::ST_ADD;
        end
      end
      sha1bsh_pkg::ST_ADD: begin
        h_d[0] = h_q[0] + a_q;
        h_d[1] = h_q[1] + b_q;
        h_d[2] = h_q[2] + c_q;
        h_d[3] = h_q[3] + d_q;
        h_d[4] = h_q[4] + e_q;
        if (!fin_q) begin
          state_d = sha1bsh_pkg::ST_IDLE;
        end else if (lend_q) begin
          state_d = sha1bsh_pkg::ST_OUT;
        end else begin
          state_d = sha1bsh_pkg::ST_PAD;
        end
      end
      sha1bsh_pkg::ST_OUT: begin
        if (!out_stall_i) begin
          if (oidx_q == sha1bsh_pkg::LAST_WORD) begin
            // Digest delivered: back to the initial vector
            oidx_d  = 3'd0;
            h_d     = sha1bsh_pkg::IV;
            fill_d  = 6'd0;
            bits_d  = 64'd0;
            fin_d   = 1'b0;
            lend_d  = 1'b0;
            state_d = sha1bsh_pkg::ST_IDLE;
          end else begin
            oidx_d = oidx_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = sha1bsh_pkg::ST_IDLE;
      end
    endcase

    // Pack bytes big-endian; write the word when its fourth byte arrives
    if (push_en) begin
      fill_d    = fill_q + 6'd1;
      pack_d    = {pack_q[15:0], push_byte};
      ram_wdata = {pack_q, push_byte};
      ram_we    = (fill_q[1:0] == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1bsh_pkg::ST_IDLE;
      fill_q  <= 6'd0;
      bits_q  <= 64'd0;
      rnd_q   <= 7'd0;
      fin_q   <= 1'b0;
      lend_q  <= 1'b0;
      oidx_q  <= 3'd0;
      h_q     <= sha1bsh_pkg::IV;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      bits_q  <= bits_d;
      rnd_q   <= rnd_d;
      fin_q   <= fin_d;
      lend_q  <= lend_d;
      oidx_q  <= oidx_d;
      h_q     <= h_d;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    pack_q <= pack_d;
    a_q    <= a_d;
    b_q    <= b_d;
    c_q    <= c_d;
    d_q    <= d_d;
    e_q    <= e_d;
    w_q    <= w_d;
  end

  assign in_stall_o    = (state_q != sha1bsh_pkg::ST_IDLE);
  assign out_valid_o   = (state_q == sha1bsh_pkg::ST_OUT);
  assign digest_word_o = h_q[oidx_q];
  assign digest_last_o = (oidx_q == sha1bsh_pkg::LAST_WORD);

endmodule

// ----- sv/sha1bsh_ram.sv -----
// ----------------------------------------------------------------------------
// sha1bsh_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module sha1bsh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte-stream SHA-1 hasher. Drives messages one
// byte per transfer, computes each digest with an independent SHA-1 model in
// the bench, and compares every digest word and its last flag in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Input kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  // SHA-1 constants, kept local so the bench does not lean on the design
  localparam logic [31:0] RK0 = 32'h5a827999;
  localparam logic [31:0] RK1 = 32'h6ed9eba1;
  localparam logic [31:0] RK2 = 32'h8f1bbcdc;
  localparam logic [31:0] RK3 = 32'hca62c1d6;
  localparam logic [31:0] START_H [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };
  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_POS    = 6'd56;

  // Cycles to let pass after the last digest word before the verdict
  localparam int unsigned SETTLE_CYCLES = 200;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        kind_i      = KIND_DATA;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic        digest_last_o;

  // Bench copy of the hasher state
  logic [31:0] hash_acc [5];
  logic [7:0]  blk_buf [64];
  logic [5:0]  fill_pos;
  logic [63:0] msg_bits;

  // Digest words still owed by the block, oldest first
  digest_beat_t digest_q [$];

  int unsigned err_cnt       = 0;
  int unsigned phase_items   = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_left     = 0;

  sha1_byte_stream_hasher u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digest_word_o(digest_word_o),
    .digest_last_o(digest_last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Digest model
  // --------------------------------------------------------------------------

  function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic void clear_hash_state();
    for (int i = 0; i < 5; i++) hash_acc[i] = START_H[i];
    fill_pos = '0;
    msg_bits = '0;
  endfunction

  // Run the 80 rounds over the full block buffer with a 16-word rolling schedule
  function automatic void compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t_sum;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
    end
    a = hash_acc[0];
    b = hash_acc[1];
    c = hash_acc[2];
    d = hash_acc[3];
    e = hash_acc[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16) begin
        w[t % 16] = rol32(w[(t + 13) % 16] ^ w[(t + 8) % 16] ^
                          w[(t + 2) % 16] ^ w[t % 16], 1);
      end
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = RK0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = RK1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RK2;
      end else begin
        f = b ^ c ^ d;
        k = RK3;
      end
      t_sum = rol32(a, 5) + f + e + k + w[t % 16];
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t_sum;
    end
    hash_acc[0] += a;
    hash_acc[1] += b;
    hash_acc[2] += c;
    hash_acc[3] += d;
    hash_acc[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    blk_buf[fill_pos] = v;
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) compress_block();
  endfunction

  // Update the model for one accepted transfer; a finalize queues five words
  function automatic void predict_digest(input logic kind, input logic [7:0] v);
    digest_beat_t beat;
    if (kind == KIND_DATA) begin
      absorb_byte(v);
      msg_bits += 64'd8;
    end else begin
      absorb_byte(PAD_BYTE);
      while (fill_pos != LEN_POS) absorb_byte(8'h00);
      for (int j = 0; j < 8; j++) absorb_byte(msg_bits[63 - 8*j -: 8]);
      for (int j = 0; j < 5; j++) begin
        beat.word = hash_acc[j];
        beat.last = (j == 4);
        digest_q.insert(digest_q.size(), beat);
      end
      clear_hash_state();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: check each transfer, then pick the stall for the next cycle
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    digest_beat_t want;
    // Signals read here still hold their values from just before the edge
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_q.size() == 0) begin
        $display("%t unexpected digest transfer: expected none, actual word %h last %b",
                 $realtime, digest_word_o, digest_last_o);
        err_cnt++;
      end else begin
        want = digest_q.pop_front();
        if (digest_word_o !== want.word) begin
          $display("%t digest_word mismatch: expected %h, actual %h",
                   $realtime, want.word, digest_word_o);
          err_cnt++;
        end
        if (digest_last_o !== want.last) begin
          $display("%t digest_last mismatch: expected %b, actual %b",
                   $realtime, want.last, digest_last_o);
          err_cnt++;
        end
      end
    end
    // A requested hold-off wins over the random stall pattern
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one item, after a random number of idle cycles, and hold it until
  // the transfer happens. Valid stays high on return so that back-to-back
  // items never see valid dropped and raised in the same step.
  task automatic send_item(input logic kind, input logic [7:0] v);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    data_byte_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_digest(kind, v);
    phase_items++;
  endtask

  task automatic send_random_message(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(KIND_DATA, 8'($urandom_range(255, 0)));
    send_item(KIND_FINAL, 8'($urandom_range(255, 0)));
  endtask

  // Drop valid and wait for every owed digest word; never returns without waiting on the clock
  task automatic drain_digests();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (digest_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty message twice in a row; the byte on a finalize must be ignored
  task automatic test_empty_message();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(KIND_FINAL, 8'h00);
    send_item(KIND_FINAL, 8'hff);
    drain_digests();
  endtask

  // Byte extremes and a short known message
  task automatic test_byte_extremes();
    send_item(KIND_DATA, 8'h00);
    send_item(KIND_DATA, 8'hff);
    send_item(KIND_DATA, 8'h80);
    send_item(KIND_DATA, 8'h7f);
    send_item(KIND_FINAL, 8'h5a);
    send_item(KIND_DATA, 8'h61);
    send_item(KIND_DATA, 8'h62);
    send_item(KIND_DATA, 8'h63);
    send_item(KIND_FINAL, 8'ha5);
    drain_digests();
  endtask

  // One random phase: an optional message of a chosen length near a padding
  // boundary, then mostly short messages with random content
  task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stl_pct,
                                  input int unsigned edge_len, input int unsigned min_items);
    int unsigned len;
    send_idle_pct = idle_pct;
    stall_pct     = stl_pct;
    phase_items   = 0;
    if (edge_len != 0) send_random_message(edge_len);
    while (phase_items < min_items) begin
      if ($urandom_range(9, 0) == 0) len = $urandom_range(40, 13);
      else len = $urandom_range(12, 0);
      send_random_message(len);
    end
    drain_digests();
  endtask

  // Padding fits after a 55-byte tail
  task automatic test_no_idle();
    run_random_phase(0, 0, 55, 40);
  endtask

  // Full data block, then a padding-only block
  task automatic test_sender_idle();
    run_random_phase(77, 0, 64, 40);
  endtask

  // 56-byte tail forces the length into an extra block
  task automatic test_receiver_stall();
    run_random_phase(0, 77, 56, 40);
  endtask

  task automatic test_both_idle();
    run_random_phase(19, 19, 0, 30);
  endtask

  // Hold the output off for a long stretch while items keep coming, so the
  // block sits on a finished digest and stalls its input
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 500;
    send_random_message(3);
    send_random_message(5);
    send_random_message(2);
    drain_digests();
  endtask

  initial begin
    clear_hash_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_message();
    test_byte_extremes();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_output_backpressure();

    // Let any stray transfer show up before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run
  initial begin
    #2ms;
    $display("timeout waiting for transfers");
    $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sha1bsh_pkg.sv
sv/sha1bsh_ram.sv
sv/sha1_byte_stream_hasher.sv
tb/testbench.sv
